FILE: rtl/core/lwwkv_pkg.sv
// ----------------------------------------------------------------------------
// lwwkv_pkg
// Shared types, command and status codes and helpers for the last-writer-wins
// replicated key-value table.
// ----------------------------------------------------------------------------
package lwwkv_pkg;

    localparam int LWW_ENTRIES     = 64;
    localparam int LWW_VALUE_BYTES = 8;
    localparam int LWW_KEY_BYTES   = 8;

    // request commands
    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_DEL    = 2'd2;
    localparam logic [1:0] CMD_REMOTE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // register index (paddr[2])
    localparam logic REG_OWN_PEER = 1'b0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key;
        logic [63:0] value;
        logic [3:0]  val_len;
        logic [63:0] version;
        logic [31:0] src_peer;
    } lwwkv_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_value;
        logic [3:0]  read_len;
        logic [6:0]  live_count;
        logic [63:0] clock_now;
    } lwwkv_out_t;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] value;
        logic [3:0]  len;
        logic [63:0] version;
        logic [31:0] peer;
    } lwwkv_entry_t;

    // low n bytes set, all bytes for n of 8 or more
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[8*b +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/lww_replicated_kv_table_top.sv
// ----------------------------------------------------------------------------
// lww_replicated_kv_table_top
// Replicated key-value table with last-writer-wins merging under a Lamport
// clock; entries live in one on-chip memory searched one slot per cycle.
// ----------------------------------------------------------------------------
// One request is handled at a time. The key search reads the entry memory
// through its single registered read port, one live slot per cycle, and
// stops early when the key is found; a request holds the block from
// acceptance until its result is loaded into the output register.
// s_ready is high only while the sequencer is idle, and a result waits in the
// output register until taken; a result not yet taken holds the next one back,
// and with it the input. own_peer sits at byte address 0 of the APB port;
// write it only while no request is in flight.
module lww_replicated_kv_table_top
    import lwwkv_pkg::*;
#(
    parameter int ENTRIES = LWW_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  lwwkv_in_t   s_payload,

    output logic        m_valid,
    input  logic        m_ready,
    output lwwkv_out_t  m_payload,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DLOAD = 3'd3;
    localparam logic [2:0] S_CLOCK = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    lwwkv_entry_t mem [ENTRIES];
    lwwkv_entry_t rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    lwwkv_entry_t     mem_wdata;

    logic [2:0]       state_reg;
    lwwkv_in_t        req_reg;
    logic [31:0]      own_peer_reg;
    logic [CNT_W-1:0] live_reg;
    logic [63:0]      clock_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;

    logic [1:0]       status_reg;
    logic [63:0]      rval_reg;
    logic [3:0]       rlen_reg;
    logic             clk_do_reg;
    logic [63:0]      clk_in_reg;
    logic             wr_do_reg;
    logic             wr_use_clk_reg;
    logic [IDX_W-1:0] wr_addr_reg;
    lwwkv_entry_t     wr_rec_reg;

    logic             m_valid_reg;
    lwwkv_out_t       m_payload_reg;

    // decode of one request, loaded in S_EXEC
    logic [2:0]       state_next;
    logic [1:0]       status_next;
    logic [63:0]      rval_next;
    logic [3:0]       rlen_next;
    logic             clk_do_next;
    logic [63:0]      clk_in_next;
    logic             wr_do_next;
    logic             wr_use_clk_next;
    logic [IDX_W-1:0] wr_addr_next;
    lwwkv_entry_t     wr_rec_next;
    logic [CNT_W-1:0] live_next;

    // combinational helpers
    lwwkv_in_t        req_masked;
    logic             out_load;
    logic             hit_now;
    logic             scan_issue;
    logic             full;
    logic [CNT_W-1:0] last_cnt;
    logic             del_move;
    logic             fits;
    logic [63:0]      in_val_masked;
    logic             ver_newer;
    logic             ver_same;
    logic             peer_wins;
    logic [63:0]      clk_base;
    lwwkv_entry_t     rem_rec;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_OWN_PEER) ? own_peer_reg : 32'd0;

    assign out_load   = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign hit_now    = pend_reg && (rd_data_reg.key == req_reg.key);
    assign scan_issue = (state_reg == S_SCAN) && !hit_now && (scan_cnt_reg < live_reg);
    assign full       = (live_reg == CNT_W'(ENTRIES));
    assign last_cnt   = live_reg - CNT_W'(1);
    assign del_move   = (req_reg.cmd == CMD_DEL) && (req_reg.key != 64'd0) && hit_reg
                        && (CNT_W'(hit_idx_reg) < last_cnt);

    assign fits          = (req_reg.val_len <= 4'(LWW_VALUE_BYTES));
    assign in_val_masked = req_reg.value & byte_mask(req_reg.val_len);
    assign ver_newer     = (req_reg.version > rd_data_reg.version);
    assign ver_same      = (req_reg.version == rd_data_reg.version);
    assign peer_wins     = (req_reg.src_peer > rd_data_reg.peer);

    assign clk_base = (clk_in_reg >= clock_reg) ? clk_in_reg : clock_reg;

    always_comb begin
        req_masked     = s_payload;
        req_masked.key = s_payload.key & byte_mask(4'(LWW_KEY_BYTES));
    end

    always_comb begin
        rem_rec         = rd_data_reg;
        rem_rec.version = req_reg.version;
        rem_rec.peer    = req_reg.src_peer;
        if (fits) begin
            rem_rec.value = in_val_masked;
            rem_rec.len   = req_reg.val_len;
        end
    end

    always_comb begin
        state_next      = S_CLOCK;
        status_next     = ST_OK;
        rval_next       = 64'd0;
        rlen_next       = 4'd0;
        clk_do_next     = 1'b0;
        clk_in_next     = 64'd0;
        wr_do_next      = 1'b0;
        wr_use_clk_next = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_rec_next     = wr_rec_reg;
        live_next       = live_reg;
        case (req_reg.cmd)
            CMD_SET: begin
                if (req_reg.key == 64'd0 || !fits) begin
                    status_next = ST_FAIL;
                end else begin
                    clk_do_next         = 1'b1;
                    wr_rec_next.key     = req_reg.key;
                    wr_rec_next.value   = in_val_masked;
                    wr_rec_next.len     = req_reg.val_len;
                    wr_rec_next.version = 64'd0;
                    wr_rec_next.peer    = own_peer_reg;
                    wr_use_clk_next     = 1'b1;
                    if (hit_reg) begin
                        wr_do_next   = 1'b1;
                        wr_addr_next = hit_idx_reg;
                    end else if (full) begin
                        status_next = ST_FAIL;
                    end else begin
                        wr_do_next   = 1'b1;
                        wr_addr_next = live_reg[IDX_W-1:0];
                        live_next    = live_reg + CNT_W'(1);
                    end
                end
            end
            CMD_GET: begin
                if (!hit_reg) begin
                    status_next = ST_FAIL;
                end else if (rd_data_reg.len != 4'd0
                             && req_reg.val_len < rd_data_reg.len) begin
                    status_next = ST_SHORT;
                end else begin
                    rval_next = rd_data_reg.value & byte_mask(rd_data_reg.len);
                    rlen_next = rd_data_reg.len;
                end
            end
            CMD_DEL: begin
                if (req_reg.key == 64'd0 || !hit_reg) begin
                    status_next = ST_FAIL;
                end else begin
                    live_next = last_cnt;
                    if (del_move) begin
                        // last entry fills the freed slot
                        wr_addr_next = hit_idx_reg;
                        state_next   = S_DLOAD;
                    end
                end
            end
            default: begin
                if (req_reg.src_peer != own_peer_reg) begin
                    if (hit_reg) begin
                        wr_rec_next  = rem_rec;
                        wr_addr_next = hit_idx_reg;
                        if (ver_newer || (ver_same && peer_wins)) begin
                            wr_do_next = 1'b1;
                        end
                        if (ver_newer || ver_same) begin
                            clk_do_next = 1'b1;
                            clk_in_next = req_reg.version;
                        end
                    end else if (full) begin
                        status_next = ST_FAIL;
                    end else begin
                        wr_do_next          = 1'b1;
                        wr_addr_next        = live_reg[IDX_W-1:0];
                        wr_rec_next.key     = req_reg.key;
                        wr_rec_next.value   = fits ? in_val_masked : 64'd0;
                        wr_rec_next.len     = fits ? req_reg.val_len : 4'd0;
                        wr_rec_next.version = req_reg.version;
                        wr_rec_next.peer    = req_reg.src_peer;
                        clk_do_next         = 1'b1;
                        clk_in_next         = req_reg.version;
                        live_next           = live_reg + CNT_W'(1);
                    end
                end
            end
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = scan_cnt_reg[IDX_W-1:0];
        if (scan_issue) begin
            rd_en = 1'b1;
        end else if (state_reg == S_EXEC && del_move) begin
            rd_en   = 1'b1;
            rd_addr = last_cnt[IDX_W-1:0];
        end
    end

    always_comb begin
        mem_we            = (state_reg == S_WRITE) && wr_do_reg;
        mem_wdata         = wr_rec_reg;
        if (wr_use_clk_reg) begin
            mem_wdata.version = clock_reg;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr_reg] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            own_peer_reg   <= 32'd0;
            live_reg       <= '0;
            clock_reg      <= 64'd0;
            scan_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            status_reg     <= ST_OK;
            rval_reg       <= 64'd0;
            rlen_reg       <= 4'd0;
            clk_do_reg     <= 1'b0;
            clk_in_reg     <= 64'd0;
            wr_do_reg      <= 1'b0;
            wr_use_clk_reg <= 1'b0;
            wr_addr_reg    <= '0;
            wr_rec_reg     <= '0;
            req_reg        <= '0;
            m_valid_reg    <= 1'b0;
            m_payload_reg  <= '0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_OWN_PEER) begin
                own_peer_reg <= pwdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg      <= req_masked;
                        scan_cnt_reg <= '0;
                        pend_reg     <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit_now) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= pend_idx_reg;
                        pend_reg    <= 1'b0;
                        state_reg   <= S_EXEC;
                    end else if (scan_issue) begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= scan_cnt_reg[IDX_W-1:0];
                        scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    end else begin
                        hit_reg   <= 1'b0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    status_reg     <= status_next;
                    rval_reg       <= rval_next;
                    rlen_reg       <= rlen_next;
                    clk_do_reg     <= clk_do_next;
                    clk_in_reg     <= clk_in_next;
                    wr_do_reg      <= wr_do_next;
                    wr_use_clk_reg <= wr_use_clk_next;
                    wr_addr_reg    <= wr_addr_next;
                    wr_rec_reg     <= wr_rec_next;
                    live_reg       <= live_next;
                    state_reg      <= state_next;
                end
                S_DLOAD: begin
                    wr_rec_reg <= rd_data_reg;
                    wr_do_reg  <= 1'b1;
                    state_reg  <= S_WRITE;
                end
                S_CLOCK: begin
                    // move past the incoming version, saturating at all ones
                    if (clk_do_reg) begin
                        clock_reg <= (clk_base == {64{1'b1}}) ? clk_base
                                                              : clk_base + 64'd1;
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        m_payload_reg.status     <= status_reg;
                        m_payload_reg.read_value <= rval_reg;
                        m_payload_reg.read_len   <= rlen_reg;
                        m_payload_reg.live_count <= 7'(live_reg);
                        m_payload_reg.clock_now  <= clock_reg;
                        state_reg                <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
